>>> sv/bts_pkg.sv
// Package for the bilinear texture sampler: widths, register and opcode codes,
// beat structs and the 8-bit lerp helper. No dependencies.
package bts_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_DIM   = 256;
  localparam int CFG_W     = 9;
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int ADDR_W    = 16;
  localparam int TEXEL_W   = 24;
  localparam int DEPTH     = 1 << ADDR_W;
  localparam int POS_W     = FRAC_BITS + IDX_W;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_TEX_WIDTH  = 1'b0,
    REG_TEX_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic               opcode;
    logic [15:0]        texel_index;
    logic [7:0]         in_red;
    logic [7:0]         in_green;
    logic [7:0]         in_blue;
    logic signed [31:0] u_coord;
    logic signed [31:0] v_coord;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_item_t;

  localparam logic [7:0] MAGENTA_RB = 8'd255;
  localparam logic [7:0] MAGENTA_G  = 8'd0;

  // floor(a + (b-a)*t / 2^FRAC_BITS); the result always lies between a and b
  function automatic logic [7:0] lerp8(logic [7:0] a, logic [7:0] b,
                                       logic [FRAC_BITS-1:0] t);
    logic signed [8:0]            d;
    logic signed [FRAC_BITS+9:0]  prod;
    logic signed [FRAC_BITS+9:0]  acc;
    d    = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = d * $signed({1'b0, t});
    acc  = $signed({2'b00, a, {FRAC_BITS{1'b0}}}) + prod;
    return acc[FRAC_BITS+7:FRAC_BITS];
  endfunction

endpackage

>>> sv/bilinear_texture_sampler.sv
// Bilinear texture sampler with repeat wrapping, six-stage pipeline.
// Depends on bts_pkg and bts_texram (two copies, one per texel row).
//
//   channel | ports                          | beat
//   --------+--------------------------------+--------------------------------
//   input   | in_valid, in_stall, in_data    | texel write or sample request
//   result  | out_valid, out_stall, out_data | filtered RGB, one per sample
//   config  | cfg_we, cfg_index, cfg_wdata   | tex_width / tex_height write
//
// One beat enters per cycle while the output is not held; after the input register
// a sample passes through scale, address, texel read, horizontal blend and vertical
// blend, each of which takes one register stage. Two mirrored memories with two
// read ports each give the four neighbors in the same cycle.
// rst_n clears the stage valid bits and the dimensions; the texel store keeps
// its contents. A held output holds the whole pipeline.
module bilinear_texture_sampler import bts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0] tex_width_r, tex_height_r;
  logic [CFG_W-1:0] w_eff, h_eff;
  logic [IDX_W-1:0] wm1, hm1;
  logic             empty;
  logic             adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= '0;
      tex_height_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEX_WIDTH:  tex_width_r  <= cfg_wdata;
        REG_TEX_HEIGHT: tex_height_r <= cfg_wdata;
      endcase
    end
  end

  assign w_eff = (tex_width_r  > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : tex_width_r;
  assign h_eff = (tex_height_r > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : tex_height_r;
  assign wm1   = IDX_W'(w_eff - CFG_W'(1));
  assign hm1   = IDX_W'(h_eff - CFG_W'(1));
  assign empty = (w_eff == '0) || (h_eff == '0);

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage 1: input register
  logic                 s1_valid_r, s1_op_r;
  logic [ADDR_W-1:0]    s1_idx_r;
  logic [TEXEL_W-1:0]   s1_rgb_r;
  logic [FRAC_BITS-1:0] s1_fu_r, s1_fv_r;

  // stage 2: scaled positions
  logic                 s2_valid_r, s2_op_r;
  logic [ADDR_W-1:0]    s2_idx_r;
  logic [TEXEL_W-1:0]   s2_rgb_r;
  logic [POS_W-1:0]     s2_px_r, s2_py_r;

  // stage 3: texel addresses and weights
  logic                 s3_valid_r, s3_op_r;
  logic [ADDR_W-1:0]    s3_idx_r;
  logic [TEXEL_W-1:0]   s3_rgb_r;
  logic [ADDR_W-1:0]    s3_a00_r, s3_a10_r, s3_a01_r, s3_a11_r;
  logic [FRAC_BITS-1:0] s3_tx_r, s3_ty_r;

  // stage 4: texels from memory
  logic                 s4_valid_r;
  logic [FRAC_BITS-1:0] s4_tx_r, s4_ty_r;
  logic [TEXEL_W-1:0]   c00, c10, c01, c11;

  // stage 5: horizontal blends
  logic                 s5_valid_r;
  logic [FRAC_BITS-1:0] s5_ty_r;
  logic [TEXEL_W-1:0]   s5_top_r, s5_bot_r;

  out_item_t            out_r, out_nxt;
  logic                 out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      // drop writes once they have reached the memory
      s4_valid_r  <= s3_valid_r && (s3_op_r == OP_SAMPLE);
      s5_valid_r  <= s4_valid_r;
      out_valid_r <= s5_valid_r;
    end
  end

  // position and address arithmetic
  logic [IDX_W-1:0]   x0, y0, x1, y1;
  logic [CFG_W-1:0]   x0p1, y0p1;
  logic [ADDR_W-1:0]  row0, row1;

  assign x0   = s2_px_r[POS_W-1:FRAC_BITS];
  assign y0   = s2_py_r[POS_W-1:FRAC_BITS];
  assign x0p1 = CFG_W'(x0) + CFG_W'(1);
  assign y0p1 = CFG_W'(y0) + CFG_W'(1);
  assign x1   = (x0p1 < w_eff) ? IDX_W'(x0p1) : wm1;
  assign y1   = (y0p1 < h_eff) ? IDX_W'(y0p1) : hm1;
  assign row0 = ADDR_W'(y0 * w_eff);
  assign row1 = ADDR_W'(y1 * w_eff);

  always_comb begin
    out_nxt.out_red   = lerp8(s5_top_r[23:16], s5_bot_r[23:16], s5_ty_r);
    out_nxt.out_green = lerp8(s5_top_r[15:8],  s5_bot_r[15:8],  s5_ty_r);
    out_nxt.out_blue  = lerp8(s5_top_r[7:0],   s5_bot_r[7:0],   s5_ty_r);
    if (empty) begin
      out_nxt.out_red   = MAGENTA_RB;
      out_nxt.out_green = MAGENTA_G;
      out_nxt.out_blue  = MAGENTA_RB;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r  <= in_data.opcode;
      s1_idx_r <= in_data.texel_index;
      s1_rgb_r <= {in_data.in_red, in_data.in_green, in_data.in_blue};
      s1_fu_r  <= in_data.u_coord[FRAC_BITS-1:0];
      s1_fv_r  <= in_data.v_coord[FRAC_BITS-1:0];

      s2_op_r  <= s1_op_r;
      s2_idx_r <= s1_idx_r;
      s2_rgb_r <= s1_rgb_r;
      s2_px_r  <= s1_fu_r * wm1;
      s2_py_r  <= s1_fv_r * hm1;

      s3_op_r  <= s2_op_r;
      s3_idx_r <= s2_idx_r;
      s3_rgb_r <= s2_rgb_r;
      s3_a00_r <= row0 + ADDR_W'(x0);
      s3_a10_r <= row0 + ADDR_W'(x1);
      s3_a01_r <= row1 + ADDR_W'(x0);
      s3_a11_r <= row1 + ADDR_W'(x1);
      s3_tx_r  <= s2_px_r[FRAC_BITS-1:0];
      s3_ty_r  <= s2_py_r[FRAC_BITS-1:0];

      s4_tx_r  <= s3_tx_r;
      s4_ty_r  <= s3_ty_r;

      s5_ty_r  <= s4_ty_r;
      s5_top_r <= {lerp8(c00[23:16], c10[23:16], s4_tx_r),
                   lerp8(c00[15:8],  c10[15:8],  s4_tx_r),
                   lerp8(c00[7:0],   c10[7:0],   s4_tx_r)};
      s5_bot_r <= {lerp8(c01[23:16], c11[23:16], s4_tx_r),
                   lerp8(c01[15:8],  c11[15:8],  s4_tx_r),
                   lerp8(c01[7:0],   c11[7:0],   s4_tx_r)};

      out_r    <= out_nxt;
    end
  end

  logic wr_en;
  assign wr_en = adv && s3_valid_r && (s3_op_r == OP_WRITE);

  bts_texram u_ram_row0 (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (s3_idx_r),
    .wr_data   (s3_rgb_r),
    .rd_en     (adv),
    .rd_addr_a (s3_a00_r),
    .rd_addr_b (s3_a10_r),
    .rd_data_a (c00),
    .rd_data_b (c10)
  );

  bts_texram u_ram_row1 (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (s3_idx_r),
    .wr_data   (s3_rgb_r),
    .rd_en     (adv),
    .rd_addr_a (s3_a01_r),
    .rd_addr_b (s3_a11_r),
    .rd_data_a (c01),
    .rd_data_b (c11)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> sv/bts_texram.sv
// Texel memory: one write port, two registered read ports.
// Depends on bts_pkg for widths.
module bts_texram import bts_pkg::*; (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [TEXEL_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr_a,
  input  logic [ADDR_W-1:0]  rd_addr_b,
  output logic [TEXEL_W-1:0] rd_data_a,
  output logic [TEXEL_W-1:0] rd_data_b
);

  logic [TEXEL_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data while the pipeline is held
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

>>> sv/bts_checker.sv
// Port-level checks for bilinear_texture_sampler, bound to the top level.
// Depends on bts_pkg for the beat structs.
module bts_checker import bts_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("held result beat changed");

  // an empty output register never holds the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_hold_propagates: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while pipeline held");

endmodule

bind bilinear_texture_sampler bts_checker u_bts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
